### hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// Timer prescaler select package
// Shared constants, prescaler tables and pipeline stage types.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int PRESCALER_COUNT = 5;
  localparam int FRACTION_BITS   = 16;
  localparam int TABLE_SIZE      = 5;

  localparam int HZ_W    = 24;
  localparam int CLK_W   = 24;
  localparam int COUNT_W = 9;
  localparam int INDEX_W = 3;

  // Count divider: one quotient bit per stage, divisor pre-shifted by COUNT_W-1.
  localparam int DIV_W      = HZ_W + COUNT_W;
  localparam int CNT_STAGES = COUNT_W;

  // Achieved-frequency divider: constant numerator over a 9-bit count.
  localparam int STEPS_PER_STAGE = 8;
  localparam int QUO_W      = CLK_W + FRACTION_BITS;
  localparam int RCP_STAGES = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int WORK_W     = RCP_STAGES * STEPS_PER_STAGE;
  localparam int REM_W      = COUNT_W + 1;
  localparam int DIST_W     = QUO_W;

  // Prescaled clocks; the window tops equal the clocks.
  localparam logic [TABLE_SIZE-1:0][CLK_W-1:0] CLOCK_HZ = {
    24'd15625, 24'd62500, 24'd250000, 24'd2000000, 24'd16000000
  };
  localparam logic [TABLE_SIZE-1:0][HZ_W-1:0] WINDOW_LOW = {
    24'd61, 24'd245, 24'd980, 24'd7843, 24'd62745
  };

  typedef struct packed {
    logic                                       valid;
    logic [HZ_W-1:0]                            hz;
    logic [PRESCALER_COUNT-1:0]                 usable;
    logic [PRESCALER_COUNT-1:0][DIV_W-1:0]      rem;
    logic [DIV_W-1:0]                           dsh;
    logic [PRESCALER_COUNT-1:0][COUNT_W-1:0]    quo;
  } cnt_t;

  typedef struct packed {
    logic                                       valid;
    logic [HZ_W-1:0]                            hz;
    logic [PRESCALER_COUNT-1:0]                 usable;
    logic [PRESCALER_COUNT-1:0][COUNT_W-1:0]    cnt;
    logic [PRESCALER_COUNT-1:0][REM_W-1:0]      rem;
    logic [PRESCALER_COUNT-1:0][WORK_W-1:0]     work;
  } rcp_t;

  typedef struct packed {
    logic                                       valid;
    logic [PRESCALER_COUNT-1:0]                 ok;
    logic [PRESCALER_COUNT-1:0][COUNT_W-1:0]    cnt;
    logic [PRESCALER_COUNT-1:0][DIST_W-1:0]     diff;
    logic [DIST_W-1:0]                          best_dist;
    logic [COUNT_W-1:0]                         best_cnt;
    logic [INDEX_W-1:0]                         best_idx;
    logic                                       found;
  } pick_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] cnt;
    logic [DIST_W-1:0]  diff;
  } cand_t;

endpackage

### hw/rtl/tps_cnt_stage.sv
// ----------------------------------------------------------------------------
// Count divider stage
// One restoring step of round(clock / target) on every prescaler lane.
// ----------------------------------------------------------------------------
module tps_cnt_stage
  import tps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  cnt_t d,
  output cnt_t q
);

  cnt_t nxt;

  // Compare-subtract against the shared shifted divisor, then halve it.
  always_comb begin
    nxt = d;
    for (int i = 0; i < PRESCALER_COUNT; i++) begin
      if (d.rem[i] >= d.dsh) begin
        nxt.rem[i] = d.rem[i] - d.dsh;
        nxt.quo[i] = {d.quo[i][COUNT_W-2:0], 1'b1};
      end else begin
        nxt.quo[i] = {d.quo[i][COUNT_W-2:0], 1'b0};
      end
    end
    nxt.dsh = d.dsh >> 1;
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

### hw/rtl/tps_rcp_stage.sv
// ----------------------------------------------------------------------------
// Achieved frequency divider stage
// Eight long-division steps of (clock << fraction bits) / count per lane.
// ----------------------------------------------------------------------------
module tps_rcp_stage
  import tps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  rcp_t d,
  output rcp_t q
);

  rcp_t nxt;

  // The work register shifts numerator bits out and quotient bits in.
  always_comb begin
    logic [REM_W-1:0]  r2;
    logic [REM_W-1:0]  rem;
    logic [WORK_W-1:0] work;
    logic              qbit;
    nxt = d;
    for (int i = 0; i < PRESCALER_COUNT; i++) begin
      rem  = d.rem[i];
      work = d.work[i];
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        r2 = {rem[REM_W-2:0], work[WORK_W-1]};
        qbit = (r2 >= {1'b0, d.cnt[i]});
        if (qbit) begin
          rem = r2 - {1'b0, d.cnt[i]};
        end else begin
          rem = r2;
        end
        work = {work[WORK_W-2:0], qbit};
      end
      nxt.rem[i]  = rem;
      nxt.work[i] = work;
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

### hw/rtl/tps_pick_stage.sv
// ----------------------------------------------------------------------------
// Prescaler pick stage
// Weighs one candidate lane against the best one found so far.
// ----------------------------------------------------------------------------
module tps_pick_stage
  import tps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [INDEX_W-1:0] lane,
  input  cand_t              cand,
  input  pick_t              d,
  output pick_t              q
);

  pick_t nxt;

  // A strictly smaller distance wins, so on a tie the earlier lane stays.
  always_comb begin
    nxt = d;
    if (cand.ok && (cand.diff < d.best_dist)) begin
      nxt.best_dist = cand.diff;
      nxt.best_cnt  = cand.cnt;
      nxt.best_idx  = lane;
      nxt.found     = 1'b1;
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

### hw/rtl/timer_prescaler_select_unit.sv
// ----------------------------------------------------------------------------
// Timer prescaler select unit
// Chooses the prescaler and rounded timer count nearest a wanted frequency.
// ----------------------------------------------------------------------------
//  Channel  Signals                                      Direction
//  input    in_valid, in_stall, target_hz                into the block
//  output   out_valid, out_stall, timer_count,           out of the block
//           prescaler_index, found
//
// One transaction is accepted per cycle while in_stall is low; its result passes
// through 9 count-divider stages, 5 frequency-divider stages, 5 pick stages
// and the output register.
// Reset clears only the valid bits of the pipeline.
// When the output stalls, the pipeline still moves one transaction into a
// skid register; in_stall rises only while that skid register is full.
// ----------------------------------------------------------------------------
module timer_prescaler_select_unit
  import tps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [HZ_W-1:0]    target_hz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] timer_count,
  output logic [INDEX_W-1:0] prescaler_index,
  output logic               found
);

  logic adv;

  cnt_t  cnt_pipe  [0:CNT_STAGES];
  rcp_t  rcp_pipe  [0:RCP_STAGES];
  pick_t pick_pipe [0:PRESCALER_COUNT];

  logic               skid_valid;
  logic [COUNT_W-1:0] skid_cnt;
  logic [INDEX_W-1:0] skid_idx;
  logic               skid_found;
  logic               load_out;
  logic               load_skid;

  assign adv      = !skid_valid;
  assign in_stall = skid_valid;

  // Window checks and rounding numerators (2 * clock + target) per lane.
  always_comb begin
    cnt_pipe[0].valid = in_valid;
    cnt_pipe[0].hz    = target_hz;
    cnt_pipe[0].dsh   = {target_hz, 1'b0, {(COUNT_W - 1){1'b0}}};
    for (int i = 0; i < PRESCALER_COUNT; i++) begin
      cnt_pipe[0].usable[i] = (target_hz >= WINDOW_LOW[i]) &&
                              (target_hz <= CLOCK_HZ[i]) && (target_hz != '0);
      cnt_pipe[0].rem[i]    = DIV_W'({CLOCK_HZ[i], 1'b0}) + DIV_W'(target_hz);
      cnt_pipe[0].quo[i]    = '0;
    end
  end

  // Count divider chain.
  for (genvar k = 0; k < CNT_STAGES; k++) begin : g_cnt
    tps_cnt_stage u_stage (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (cnt_pipe[k]),
      .q   (cnt_pipe[k + 1])
    );
  end

  // Load the constant numerators for the achieved frequency division.
  always_comb begin
    rcp_pipe[0].valid  = cnt_pipe[CNT_STAGES].valid;
    rcp_pipe[0].hz     = cnt_pipe[CNT_STAGES].hz;
    rcp_pipe[0].usable = cnt_pipe[CNT_STAGES].usable;
    rcp_pipe[0].cnt    = cnt_pipe[CNT_STAGES].quo;
    for (int i = 0; i < PRESCALER_COUNT; i++) begin
      rcp_pipe[0].rem[i]  = '0;
      rcp_pipe[0].work[i] = WORK_W'({CLOCK_HZ[i], {FRACTION_BITS{1'b0}}});
    end
  end

  // Achieved frequency divider chain.
  for (genvar k = 0; k < RCP_STAGES; k++) begin : g_rcp
    tps_rcp_stage u_stage (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (rcp_pipe[k]),
      .q   (rcp_pipe[k + 1])
    );
  end

  // Distances to the target; the best starts at an achieved value of zero.
  always_comb begin
    logic [DIST_W-1:0] tfx;
    logic [DIST_W-1:0] ach;
    tfx = DIST_W'({rcp_pipe[RCP_STAGES].hz, {FRACTION_BITS{1'b0}}});
    pick_pipe[0].valid     = rcp_pipe[RCP_STAGES].valid;
    pick_pipe[0].cnt       = rcp_pipe[RCP_STAGES].cnt;
    pick_pipe[0].best_dist = tfx;
    pick_pipe[0].best_cnt  = '0;
    pick_pipe[0].best_idx  = '0;
    pick_pipe[0].found     = 1'b0;
    for (int i = 0; i < PRESCALER_COUNT; i++) begin
      ach = rcp_pipe[RCP_STAGES].work[i][QUO_W-1:0];
      pick_pipe[0].ok[i]   = rcp_pipe[RCP_STAGES].usable[i] &&
                             (rcp_pipe[RCP_STAGES].cnt[i] != '0);
      pick_pipe[0].diff[i] = (tfx >= ach) ? (tfx - ach) : (ach - tfx);
    end
  end

  // Pick chain, one lane per stage in index order.
  for (genvar k = 0; k < PRESCALER_COUNT; k++) begin : g_pick
    cand_t cand;
    assign cand.ok   = pick_pipe[k].ok[k];
    assign cand.cnt  = pick_pipe[k].cnt[k];
    assign cand.diff = pick_pipe[k].diff[k];
    tps_pick_stage u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .lane (INDEX_W'(k)),
      .cand (cand),
      .d    (pick_pipe[k]),
      .q    (pick_pipe[k + 1])
    );
  end

  // Output register with a one-entry skid behind it.
  assign load_out  = !(out_valid && out_stall);
  assign load_skid = out_valid && out_stall && pick_pipe[PRESCALER_COUNT].valid &&
                     !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || pick_pipe[PRESCALER_COUNT].valid;
      skid_valid <= 1'b0;
    end else if (load_skid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        timer_count     <= skid_cnt;
        prescaler_index <= skid_idx;
        found           <= skid_found;
      end else begin
        timer_count     <= pick_pipe[PRESCALER_COUNT].best_cnt;
        prescaler_index <= pick_pipe[PRESCALER_COUNT].best_idx;
        found           <= pick_pipe[PRESCALER_COUNT].found;
      end
    end else if (load_skid) begin
      skid_cnt   <= pick_pipe[PRESCALER_COUNT].best_cnt;
      skid_idx   <= pick_pipe[PRESCALER_COUNT].best_idx;
      skid_found <= pick_pipe[PRESCALER_COUNT].found;
    end
  end

endmodule
